// File: hw/rtl/kst_pkg.sv
// Shared types, character constants, token codes and helpers for the keyword string tokenizer.
// Used by kst_scan, kst_outq and keyword_string_tokenizer_top.
// No dependencies.
package kst_pkg;

    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int LINE_WIDTH_DEF   = 20;
    localparam int Q_DEPTH          = 4;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_O = 8'h6F;

    localparam logic [2:0] KIND_END     = 3'd0;
    localparam logic [2:0] KIND_LBRACE  = 3'd1;
    localparam logic [2:0] KIND_RBRACE  = 3'd2;
    localparam logic [2:0] KIND_ENTRY   = 3'd3;
    localparam logic [2:0] KIND_OUT     = 3'd4;
    localparam logic [2:0] KIND_STRING  = 3'd5;
    localparam logic [2:0] KIND_WORD    = 3'd6;
    localparam logic [2:0] KIND_UNKNOWN = 3'd7;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNTERM    = 2'd1;
    localparam logic [1:0] ERR_STRING_NL = 2'd2;

    localparam logic [2:0] WLEN_MAX   = 3'd6;
    localparam logic [2:0] ENTRY_LEN  = 3'd5;
    localparam logic [2:0] OUT_LEN    = 3'd3;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_DASH    = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_WORD    = 5'b01000,
        MODE_STRING  = 5'b10000
    } t_mode;

    // Write strobes from the scanner to the result queue; push1 only with push0.
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    function automatic logic name_start_char(input logic [7:0] c);
        return (c == CH_UNDER) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic name_body_char(input logic [7:0] c);
        return name_start_char(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [7:0] entry_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h6E;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h72;
            3'd4:    ch = 8'h79;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] out_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h6F;
            3'd1:    ch = 8'h75;
            3'd2:    ch = 8'h74;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/keyword_string_tokenizer_top.sv
// Top level of the keyword string tokenizer: input register, scanner and result queue.
// Depends on kst_pkg, kst_scan and kst_outq.
//
// One source byte is taken per beat, and a new byte can be accepted every cycle while
// o_stall is low. An accepted byte waits in the input register until the scanner takes it,
// and its zero, one or two tokens are queued for the output channel.
// A four-entry result queue decouples the two sides; the input stalls only while the
// queue cannot take two more results, so the sustained rate is one byte per cycle
// as long as the bytes average no more than one token each and the output is drained.
// The o_last flag marks the final token caused by one input byte.
module keyword_string_tokenizer_top #(
    parameter int OFFSET_WIDTH = kst_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = kst_pkg::LINE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_in_byte,
    input  logic                    i_in_end,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_token_kind,
    output logic [1:0]              o_error_code,
    output logic [LINE_WIDTH-1:0]   o_token_line,
    output logic [OFFSET_WIDTH-1:0] o_text_offset,
    output logic [OFFSET_WIDTH-1:0] o_text_length,
    output logic                    o_last
);

    localparam int RES_W = 3 + 2 + LINE_WIDTH + 2 * OFFSET_WIDTH + 1;

    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_byte;
    logic              r_end;
    logic              accept, step, q_room;
    kst_pkg::t_push    push;
    logic [RES_W-1:0]  res0, res1, head;

    assign step    = r_in_valid && q_room;
    assign o_stall = r_in_valid && !q_room;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = accept || (r_in_valid && !step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in_byte;
            r_end  <= i_in_end;
        end
    end

    kst_scan #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH),
        .RES_W        (RES_W)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_byte),
        .i_end   (r_end),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    kst_outq #(
        .DATA_W (RES_W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (res0),
        .i_data1 (res1),
        .o_room  (q_room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (head)
    );

    assign {o_token_kind, o_error_code, o_token_line,
            o_text_offset, o_text_length, o_last} = head;

    // A held byte must stay put until the scanner takes it.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |=> (r_in_valid && $stable(r_byte) && $stable(r_end)))
        else $error("pending input beat lost or changed");

endmodule

// File: hw/rtl/kst_scan.sv
// Scanner state and combinational token step for the keyword string tokenizer.
// Depends on kst_pkg; produces up to two packed results per step for kst_outq.
module kst_scan #(
    parameter int OFFSET_WIDTH = kst_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = kst_pkg::LINE_WIDTH_DEF,
    parameter int RES_W        = 3 + 2 + LINE_WIDTH + 2 * OFFSET_WIDTH + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_end,
    output kst_pkg::t_push     o_push,
    output logic [RES_W-1:0]   o_res0,
    output logic [RES_W-1:0]   o_res1
);

    kst_pkg::t_mode            r_mode, n_mode;
    logic [OFFSET_WIDTH-1:0]   r_pos, n_pos;
    logic [LINE_WIDTH-1:0]     r_line, n_line;
    logic [OFFSET_WIDTH-1:0]   r_tok_start, n_tok_start;
    logic [LINE_WIDTH-1:0]     r_tok_line, n_tok_line;
    logic [2:0]                r_wlen, n_wlen;
    logic [1:0]                r_kw, n_kw;

    logic                      end_c;
    logic [OFFSET_WIDTH-1:0]   pos_inc;
    logic [LINE_WIDTH-1:0]     line_inc;
    logic [OFFSET_WIDTH-1:0]   tok_len;
    logic [2:0]                word_kind;

    logic [2:0]                k0, k1;
    logic [1:0]                e0, e1;
    logic [LINE_WIDTH-1:0]     l0, l1;
    logic [OFFSET_WIDTH-1:0]   o0, o1, z0, z1;
    logic                      push0, push1, do_idle, ie_valid;
    logic [2:0]                ie_kind;

    assign end_c    = i_end || (i_byte == kst_pkg::CH_NUL);
    assign pos_inc  = (r_pos == '1) ? r_pos : r_pos + OFFSET_WIDTH'(1);
    assign line_inc = (r_line == '1) ? r_line : r_line + LINE_WIDTH'(1);
    assign tok_len  = r_pos - r_tok_start;

    always_comb begin
        if (r_kw[0] && r_wlen == kst_pkg::ENTRY_LEN) begin
            word_kind = kst_pkg::KIND_ENTRY;
        end else if (r_kw[1] && r_wlen == kst_pkg::OUT_LEN) begin
            word_kind = kst_pkg::KIND_OUT;
        end else begin
            word_kind = kst_pkg::KIND_WORD;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_line      = r_line;
        n_tok_start = r_tok_start;
        n_tok_line  = r_tok_line;
        n_wlen      = r_wlen;
        n_kw        = r_kw;
        k0 = kst_pkg::KIND_END; e0 = kst_pkg::ERR_NONE; l0 = '0; o0 = '0; z0 = '0;
        k1 = kst_pkg::KIND_END; e1 = kst_pkg::ERR_NONE; l1 = '0; o1 = '0; z1 = '0;
        push0    = 1'b0;
        push1    = 1'b0;
        do_idle  = 1'b0;
        ie_valid = 1'b0;
        ie_kind  = kst_pkg::KIND_UNKNOWN;

        if (i_step) begin
            if (end_c) begin
                // Flush any pending token, then the end token unless a string was open.
                unique case (r_mode)
                    kst_pkg::MODE_WORD: begin
                        push0 = 1'b1; k0 = word_kind;
                        l0 = r_tok_line; o0 = r_tok_start; z0 = tok_len;
                        push1 = 1'b1; k1 = kst_pkg::KIND_END;
                        l1 = r_line; o1 = r_pos; z1 = '0;
                    end
                    kst_pkg::MODE_DASH: begin
                        push0 = 1'b1; k0 = kst_pkg::KIND_UNKNOWN;
                        l0 = r_tok_line; o0 = r_tok_start; z0 = OFFSET_WIDTH'(1);
                        push1 = 1'b1; k1 = kst_pkg::KIND_END;
                        l1 = r_line; o1 = r_pos; z1 = '0;
                    end
                    kst_pkg::MODE_STRING: begin
                        push0 = 1'b1; k0 = kst_pkg::KIND_STRING; e0 = kst_pkg::ERR_UNTERM;
                        l0 = r_tok_line; o0 = r_tok_start; z0 = tok_len;
                    end
                    default: begin
                        push0 = 1'b1; k0 = kst_pkg::KIND_END;
                        l0 = r_line; o0 = r_pos; z0 = '0;
                    end
                endcase
                n_mode      = kst_pkg::MODE_IDLE;
                n_pos       = '0;
                n_line      = LINE_WIDTH'(1);
                n_tok_start = '0;
                n_tok_line  = LINE_WIDTH'(1);
                n_wlen      = '0;
                n_kw        = 2'b11;
            end else begin
                unique case (r_mode)
                    kst_pkg::MODE_WORD: begin
                        if (kst_pkg::name_body_char(i_byte)) begin
                            n_kw[0] = r_kw[0] && (r_wlen < kst_pkg::ENTRY_LEN)
                                      && (i_byte == kst_pkg::entry_char(r_wlen));
                            n_kw[1] = r_kw[1] && (r_wlen < kst_pkg::OUT_LEN)
                                      && (i_byte == kst_pkg::out_char(r_wlen));
                            n_wlen  = (r_wlen >= kst_pkg::WLEN_MAX) ? kst_pkg::WLEN_MAX
                                                                    : r_wlen + 3'd1;
                            n_pos   = pos_inc;
                        end else begin
                            push0 = 1'b1; k0 = word_kind;
                            l0 = r_tok_line; o0 = r_tok_start; z0 = tok_len;
                            do_idle = 1'b1;
                        end
                    end
                    kst_pkg::MODE_DASH: begin
                        if (i_byte == kst_pkg::CH_DASH) begin
                            n_mode = kst_pkg::MODE_COMMENT;
                            n_pos  = pos_inc;
                        end else begin
                            push0 = 1'b1; k0 = kst_pkg::KIND_UNKNOWN;
                            l0 = r_tok_line; o0 = r_tok_start; z0 = OFFSET_WIDTH'(1);
                            do_idle = 1'b1;
                        end
                    end
                    kst_pkg::MODE_COMMENT: begin
                        if (i_byte == kst_pkg::CH_NL) begin
                            n_line = line_inc;
                            n_mode = kst_pkg::MODE_IDLE;
                        end
                        n_pos = pos_inc;
                    end
                    kst_pkg::MODE_STRING: begin
                        if (i_byte == kst_pkg::CH_QUOTE) begin
                            push0 = 1'b1; k0 = kst_pkg::KIND_STRING;
                            l0 = r_tok_line; o0 = r_tok_start; z0 = tok_len;
                            n_pos  = pos_inc;
                            n_mode = kst_pkg::MODE_IDLE;
                        end else if (i_byte == kst_pkg::CH_NL) begin
                            push0 = 1'b1; k0 = kst_pkg::KIND_STRING;
                            e0 = kst_pkg::ERR_STRING_NL;
                            l0 = r_tok_line; o0 = r_tok_start; z0 = tok_len;
                            n_mode      = kst_pkg::MODE_IDLE;
                            n_pos       = '0;
                            n_line      = LINE_WIDTH'(1);
                            n_tok_start = '0;
                            n_tok_line  = LINE_WIDTH'(1);
                            n_wlen      = '0;
                            n_kw        = 2'b11;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase

                // The current byte is handled as from idle: whitespace is skipped, other bytes emit or open a token.
                if (do_idle) begin
                    n_mode = kst_pkg::MODE_IDLE;
                    n_pos  = pos_inc;
                    if (i_byte == kst_pkg::CH_SPACE || i_byte == kst_pkg::CH_TAB
                        || i_byte == kst_pkg::CH_CR || i_byte == kst_pkg::CH_NL) begin
                        if (i_byte == kst_pkg::CH_NL) begin
                            n_line = line_inc;
                        end
                    end else if (i_byte == kst_pkg::CH_LBRACE) begin
                        ie_valid = 1'b1; ie_kind = kst_pkg::KIND_LBRACE;
                    end else if (i_byte == kst_pkg::CH_RBRACE) begin
                        ie_valid = 1'b1; ie_kind = kst_pkg::KIND_RBRACE;
                    end else if (i_byte == kst_pkg::CH_QUOTE) begin
                        n_tok_start = pos_inc;
                        n_tok_line  = r_line;
                        n_mode      = kst_pkg::MODE_STRING;
                    end else if (kst_pkg::name_start_char(i_byte)) begin
                        n_tok_start = r_pos;
                        n_tok_line  = r_line;
                        n_wlen      = 3'd1;
                        n_kw        = {i_byte == kst_pkg::CH_LOWER_O,
                                       i_byte == kst_pkg::CH_LOWER_E};
                        n_mode      = kst_pkg::MODE_WORD;
                    end else if (i_byte == kst_pkg::CH_DASH) begin
                        n_tok_start = r_pos;
                        n_tok_line  = r_line;
                        n_mode      = kst_pkg::MODE_DASH;
                    end else begin
                        ie_valid = 1'b1; ie_kind = kst_pkg::KIND_UNKNOWN;
                    end

                    if (ie_valid) begin
                        if (push0) begin
                            push1 = 1'b1; k1 = ie_kind;
                            l1 = r_line; o1 = r_pos; z1 = OFFSET_WIDTH'(1);
                        end else begin
                            push0 = 1'b1; k0 = ie_kind;
                            l0 = r_line; o0 = r_pos; z0 = OFFSET_WIDTH'(1);
                        end
                    end
                end
            end
        end
    end

    assign o_push.push0 = push0;
    assign o_push.push1 = push1;
    assign o_res0 = {k0, e0, l0, o0, z0, !push1};
    assign o_res1 = {k1, e1, l1, o1, z1, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kst_pkg::MODE_IDLE;
            r_pos       <= '0;
            r_line      <= LINE_WIDTH'(1);
            r_tok_start <= '0;
            r_tok_line  <= LINE_WIDTH'(1);
            r_wlen      <= '0;
            r_kw        <= 2'b11;
        end else begin
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_line      <= n_line;
            r_tok_start <= n_tok_start;
            r_tok_line  <= n_tok_line;
            r_wlen      <= n_wlen;
            r_kw        <= n_kw;
        end
    end

    // An end of source leaves the counters at their restart values.
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && end_c) |=> (r_pos == '0 && r_line == LINE_WIDTH'(1)
                               && r_mode == kst_pkg::MODE_IDLE))
        else $error("counters did not restart after end of source");

    a_start_before_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_start <= r_pos)
        else $error("token start ran past the byte position");

endmodule

// File: hw/rtl/kst_outq.sv
// Small result queue between the scanner and the output channel.
// Depends on kst_pkg; takes up to two results per cycle and presents one per beat.
module kst_outq #(
    parameter int DATA_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kst_pkg::t_push     i_push,
    input  logic [DATA_W-1:0]  i_data0,
    input  logic [DATA_W-1:0]  i_data1,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [DATA_W-1:0]  o_data
);

    // The pointers wrap naturally, so the depth is a power of two.
    localparam int DEPTH = kst_pkg::Q_DEPTH;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr, n_wr;
    logic [PW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_count, n_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr    = r_wr + PW'(i_push.push0) + PW'(i_push.push1);
        n_rd    = r_rd + PW'(pop);
        n_count = r_count + CW'(i_push.push0) + CW'(i_push.push1) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push.push1) begin
            r_mem[r_wr + PW'(1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push1 |-> i_push.push0)
        else $error("second result pushed without the first");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push0 |-> o_room)
        else $error("result pushed while the queue lacked room for two");

endmodule
